// ===== hw/rtl/ist_pkg.sv =====
// Shared constants and request codes for the id set table.
package ist_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_BITS  = 16;
  localparam int KIND_W       = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

endpackage

// ===== hw/rtl/ist_if.sv =====
// Request and result channel interfaces of the id set table.
interface ist_in_if import ist_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS,
  parameter int POS_W   = $clog2(DEF_CAPACITY)
);
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_BITS-1:0] item_id;
  logic [POS_W-1:0]   position;

  modport source (output valid, kind, item_id, position, input ready);
  modport sink   (input valid, kind, item_id, position, output ready);
endinterface

interface ist_out_if import ist_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS,
  parameter int CNT_W   = $clog2(DEF_CAPACITY + 1)
);
  logic               valid;
  logic               ready;
  logic               status;
  logic [ID_BITS-1:0] result_id;
  logic [CNT_W-1:0]   entry_count;
  logic               is_empty;

  modport source (output valid, status, result_id, entry_count, is_empty, input ready);
  modport sink   (input valid, status, result_id, entry_count, is_empty, output ready);
endinterface

// ===== hw/rtl/ist_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module ist_mem import ist_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int WIDTH = DEF_ID_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/ist_seq.sv =====
// Request sequencer: bound checks, fetch, linear search and shift-down over the store.
module ist_seq import ist_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_BITS  = DEF_ID_BITS,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // request side
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [KIND_W-1:0]  req_kind,
  input  logic [ID_BITS-1:0] req_id,
  input  logic [AW-1:0]      req_pos,
  // result side
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_status,
  output logic [ID_BITS-1:0] res_id,
  output logic [CNT_W-1:0]   res_count,
  // store ports
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [ID_BITS-1:0] mem_wr_data,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [ID_BITS-1:0] mem_rd_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_GET    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [ID_BITS-1:0] NO_ID = {ID_BITS{1'b1}};
  localparam logic [CNT_W-1:0]   CAP_CNT = CNT_W'(CAPACITY);

  logic [2:0]         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic               status_r, status_nxt;
  logic [ID_BITS-1:0] rid_r, rid_nxt;

  logic [CNT_W-1:0]   ptr_m2;
  logic               hit;

  assign ptr_m2 = ptr_r - CNT_W'(2);
  // the single comparator: read data of the previous cycle against the id
  assign hit    = pend_r && (mem_rd_data == id_r);

  assign req_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res_status = status_r;
  assign res_id     = rid_r;
  assign res_count  = cnt_r;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    id_nxt      = id_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    pend_nxt    = pend_r;
    status_nxt  = status_r;
    rid_nxt     = rid_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_r[AW-1:0];
    mem_wr_data = id_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt   = req_kind;
          id_nxt     = req_id;
          pos_nxt    = req_pos;
          status_nxt = 1'b1;
          rid_nxt    = NO_ID;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_APPEND: begin
            if (id_r != NO_ID && cnt_r != CAP_CNT) begin
              mem_wr_en  = 1'b1;
              cnt_nxt    = cnt_r + CNT_W'(1);
              status_nxt = 1'b0;
            end
          end
          KIND_POP: begin
            if (cnt_r != '0) begin
              ptr_nxt   = cnt_r - CNT_W'(1);
              state_nxt = S_FETCH;
            end
          end
          KIND_READ: begin
            if (CNT_W'(pos_r) < cnt_r) begin
              ptr_nxt   = CNT_W'(pos_r);
              state_nxt = S_FETCH;
            end
          end
          KIND_REMOVE: begin
            if (id_r != NO_ID && cnt_r != '0) begin
              ptr_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_FETCH: begin
        mem_rd_en = 1'b1;
        state_nxt = S_GET;
      end
      S_GET: begin
        rid_nxt    = mem_rd_data;
        status_nxt = 1'b0;
        if (kind_r == KIND_POP) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // ptr_r is one past the entry under compare, i.e. the first source of the shift
        if (hit) begin
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else if (ptr_r < cnt_r) begin
          mem_rd_en = 1'b1;
          ptr_nxt   = ptr_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ptr_m2[AW-1:0];
          mem_wr_data = mem_rd_data;
        end
        if (ptr_r < cnt_r) begin
          mem_rd_en = 1'b1;
          ptr_nxt   = ptr_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt   = 1'b0;
          cnt_nxt    = cnt_r - CNT_W'(1);
          status_nxt = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    pos_r    <= pos_nxt;
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
  end

endmodule

// ===== hw/rtl/id_set_table_core.sv =====
// Id set table: packed list of identifiers with append, pop, read and remove.
//
// Requests arrive on in_ch (kind, item_id, position) with valid/ready; an
// item is taken when both are high. Each request gives exactly one result
// on out_ch: status (0 ok, 1 error), result_id (popped or read id, all ones
// otherwise), entry_count and is_empty after the request.
// One request is worked on at a time; in_ch.ready is high only while the
// sequencer is idle. Append and any request refused at decode (reserved
// id, full, empty, bad position) go from decode straight to the result;
// pop and read fetch one store entry first; remove searches for the id
// and, when it is found, shifts the later entries down (one store read per
// cycle through the single read port and the one id comparator).
// The next request is taken only after the sequencer has handed its
// result on and gone back to idle. Results sit in an output register; the
// next request is taken while a result waits, and the sequencer holds its
// finished result if out_ch stalls with that register still full.
// Reset (rst_n low, synchronous) empties the list at once; no clearing
// pass is needed since only slots below the count are ever read.
module id_set_table_core import ist_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_BITS  = DEF_ID_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               res_valid, res_ready;
  logic               res_status;
  logic [ID_BITS-1:0] res_id;
  logic [CNT_W-1:0]   res_count;

  logic               mem_wr_en, mem_rd_en;
  logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
  logic [ID_BITS-1:0] mem_wr_data, mem_rd_data;

  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_empty_r;

  ist_seq #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_ch.valid),
    .req_ready   (in_ch.ready),
    .req_kind    (in_ch.kind),
    .req_id      (in_ch.item_id),
    .req_pos     (in_ch.position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_status  (res_status),
    .res_id      (res_id),
    .res_count   (res_count),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ist_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ID_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register frees up in the same cycle it is drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_count_r  <= res_count;
      out_empty_r  <= (res_count == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.result_id   = out_id_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;

endmodule

// ===== tb/tb_id_set_table_core.sv =====
// Self-checking testbench for id_set_table_core: list ops against a behavioral list model.
`timescale 1ns / 100ps

module tb_id_set_table_core;
  import ist_pkg::*;

  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int ID_BITS    = DEF_ID_BITS;
  localparam int POS_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam logic [ID_BITS-1:0] NO_ID = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

  // Burst flavors for the random stimulus
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} burst_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_BITS-1:0] item_id;
    logic [POS_W-1:0]   position;
  } list_req_t;

  typedef struct packed {
    logic               status;
    logic [ID_BITS-1:0] result_id;
    logic [CNT_W-1:0]   entry_count;
    logic               is_empty;
  } list_result_t;

  logic clk;
  logic rst_n;

  ist_in_if  #(.ID_BITS(ID_BITS), .POS_W(POS_W)) in_if ();
  ist_out_if #(.ID_BITS(ID_BITS), .CNT_W(CNT_W)) out_if ();

  id_set_table_core #(
    .CAPACITY(CAPACITY),
    .ID_BITS (ID_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // List model and bookkeeping
  logic [ID_BITS-1:0] model_ids [CAPACITY];
  int                 model_count;
  list_req_t          pending_reqs[$];
  list_result_t       expected_results[$];
  logic [ID_BITS-1:0] id_pool [8];

  int send_idle_pct;
  int recv_stall_pct;
  logic in_fire;
  int error_count;
  int stall_cycles;
  int req_count, reject_count, full_rejects, remove_hits, peak_count;
  list_result_t want_res, got_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the list model and returns the result it must give.
  function automatic list_result_t apply_list_op(list_req_t r);
    list_result_t res;
    int hit;
    res.status    = 1'b1;
    res.result_id = NO_ID;
    case (r.kind)
      KIND_APPEND: begin
        if (r.item_id != NO_ID && model_count < CAPACITY) begin
          model_ids[model_count] = r.item_id;
          model_count++;
          res.status = 1'b0;
        end
      end
      KIND_POP: begin
        if (model_count > 0) begin
          model_count--;
          res.result_id = model_ids[model_count];
          model_ids[model_count] = NO_ID;
          res.status = 1'b0;
        end
      end
      KIND_READ: begin
        if (int'(r.position) < model_count) begin
          res.result_id = model_ids[r.position];
          res.status = 1'b0;
        end
      end
      KIND_REMOVE: begin
        if (r.item_id != NO_ID) begin
          hit = -1;
          for (int k = 0; k < model_count; k++)
            if (hit < 0 && model_ids[k] == r.item_id) hit = k;
          if (hit >= 0) begin
            for (int k = hit; k + 1 < model_count; k++) model_ids[k] = model_ids[k+1];
            model_count--;
            model_ids[model_count] = NO_ID;
            res.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(model_count);
    res.is_empty    = (model_count == 0);
    return res;
  endfunction

  task automatic push_req(logic [KIND_W-1:0] kind, logic [ID_BITS-1:0] id,
                          logic [POS_W-1:0] pos);
    list_req_t r;
    r.kind     = kind;
    r.item_id  = id;
    r.position = pos;
    pending_reqs.push_back(r);
  endtask

  // Mostly ids from a small pool so removes and duplicates hit often.
  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return id_pool[$urandom_range(0, 7)];
    if (r < 95) return ID_BITS'($urandom_range(0, 2**ID_BITS - 2));
    return NO_ID;
  endfunction

  task automatic queue_random(int n);
    burst_mode_t mode;
    int left, r;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    left = 0;
    mode = MODE_MIXED;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        mode = burst_mode_t'($urandom_range(0, 2));
        left = $urandom_range(30, 120);
      end
      left--;
      r = $urandom_range(0, 99);
      case (mode)
        MODE_GROW:   kind = (r < 85) ? KIND_APPEND : (r < 90) ? KIND_POP :
                            (r < 95) ? KIND_READ : KIND_REMOVE;
        MODE_SHRINK: kind = (r < 5) ? KIND_APPEND : (r < 50) ? KIND_POP :
                            (r < 60) ? KIND_READ : KIND_REMOVE;
        default:     kind = KIND_W'(r % 4);
      endcase
      pos = ($urandom_range(0, 9) < 6) ? POS_W'($urandom_range(0, 15))
                                        : POS_W'($urandom_range(0, CAPACITY - 1));
      push_req(kind, pick_id(), pos);
    end
  endtask

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid    <= 1'b1;
        in_if.kind     <= pending_reqs[0].kind;
        in_if.item_id  <= pending_reqs[0].item_id;
        in_if.position <= pending_reqs[0].position;
        void'(pending_reqs.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on request accept, check on result accept
  always @(posedge clk) begin
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        if (in_if.kind == KIND_APPEND && model_count == CAPACITY) full_rejects++;
        want_res = apply_list_op({in_if.kind, in_if.item_id, in_if.position});
        expected_results.push_back(want_res);
        req_count++;
        if (want_res.status) reject_count++;
        else if (in_if.kind == KIND_REMOVE) remove_hits++;
        if (model_count > peak_count) peak_count = model_count;
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got_res = {out_if.status, out_if.result_id, out_if.entry_count, out_if.is_empty};
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result status %0d id %h count %0d empty %0d", $time,
                   got_res.status, got_res.result_id, got_res.entry_count, got_res.is_empty);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res !== want_res) begin
            error_count++;
            $display("%0t: mismatch exp status %0d id %h count %0d empty %0d", $time,
                     want_res.status, want_res.result_id, want_res.entry_count,
                     want_res.is_empty);
            $display("%0t:          got status %0d id %h count %0d empty %0d", $time,
                     got_res.status, got_res.result_id, got_res.entry_count,
                     got_res.is_empty);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("id_set_table_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_APPEND;
    in_if.item_id  = '0;
    in_if.position = '0;
    out_if.ready   = 1'b0;
    in_fire        = 1'b0;
    stall_cycles   = 0;
    error_count    = 0;
    req_count      = 0;
    reject_count   = 0;
    full_rejects   = 0;
    remove_hits    = 0;
    peak_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_count    = 0;
    foreach (model_ids[k]) model_ids[k] = NO_ID;
    id_pool[0] = '0;
    id_pool[1] = NO_ID - ID_BITS'(1);
    id_pool[2] = {1'b1, {(ID_BITS-1){1'b0}}};
    id_pool[3] = {1'b0, {(ID_BITS-1){1'b1}}};
    for (int k = 4; k < 8; k++) id_pool[k] = ID_BITS'($urandom_range(0, 2**ID_BITS - 2));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: error paths on an empty list, duplicates, bounds, first-match remove
    push_req(KIND_APPEND, NO_ID, '0);
    push_req(KIND_POP, '0, '0);
    push_req(KIND_READ, '0, '0);
    push_req(KIND_REMOVE, NO_ID, '0);
    push_req(KIND_REMOVE, '0, '0);
    push_req(KIND_APPEND, '0, '0);
    push_req(KIND_APPEND, NO_ID - ID_BITS'(1), '0);
    push_req(KIND_APPEND, '0, '0);
    push_req(KIND_APPEND, 16'h1234, '0);
    push_req(KIND_READ, '0, '0);
    push_req(KIND_READ, '0, 6'd3);
    push_req(KIND_READ, '0, 6'd4);
    push_req(KIND_READ, '1, '1);
    push_req(KIND_REMOVE, '0, '0);
    push_req(KIND_READ, '0, 6'd0);
    push_req(KIND_READ, '0, 6'd1);
    push_req(KIND_REMOVE, 16'h5555, '0);
    push_req(KIND_POP, '0, '0);
    push_req(KIND_POP, '0, '0);
    push_req(KIND_POP, '0, '0);
    push_req(KIND_POP, '0, '0);

    // Phases: free running, slow sender, slow receiver, both throttled
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      queue_random(450);
      while (pending_reqs.size() > 0 || in_if.valid) @(posedge clk);
    end

    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() > 0) error_count++;

    $display("covered %0d requests, %0d rejected, %0d appends refused on a full list",
             req_count, reject_count, full_rejects);
    $display("%0d removes took an entry out; peak fill %0d of %0d",
             remove_hits, peak_count, CAPACITY);
    if (error_count == 0) begin
      $display("id_set_table_core regression: pass");
    end else begin
      $display("id_set_table_core regression: fail");
    end
    $finish;
  end

endmodule
